// ===== rtl/pidc_pkg.sv =====
`timescale 1ns / 1ps

package pidc_pkg;

    localparam logic REQ_COMPUTE = 1'b0;
    localparam logic REQ_CLEAR   = 1'b1;

    localparam logic MODE_POSITIONAL  = 1'b0;
    localparam logic MODE_INCREMENTAL = 1'b1;

    localparam logic [1:0] LIM_NONE = 2'd0;
    localparam logic [1:0] LIM_MAX  = 2'd1;
    localparam logic [1:0] LIM_MIN  = 2'd2;

    typedef enum logic [2:0] {
        CFG_MODE    = 3'd0,
        CFG_KP      = 3'd1,
        CFG_KI      = 3'd2,
        CFG_KD      = 3'd3,
        CFG_KI_TP   = 3'd4,
        CFG_KD_OP   = 3'd5,
        CFG_OUT_MIN = 3'd6,
        CFG_OUT_MAX = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic               req_type;
        logic signed [15:0] setpoint;
        logic signed [15:0] feedback;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] drive;
        logic [1:0]         limited;
    } t_out_item;

    typedef struct packed {
        logic               mode;
        logic signed [15:0] kp;
        logic signed [15:0] ki;
        logic signed [15:0] kd;
        logic signed [15:0] ki_times_period;
        logic signed [15:0] kd_over_period;
        logic signed [31:0] out_min;
        logic signed [31:0] out_max;
    } t_cfg;

    typedef struct packed {
        logic signed [16:0] last_error;
        logic signed [16:0] previous_error;
        logic signed [31:0] error_sum;
        logic signed [31:0] last_drive;
    } t_state;

endpackage

// ===== rtl/pid_controller_two_mode.sv =====
`timescale 1ns / 1ps

// Single-channel fixed-point PID controller, positional or incremental form.
// The block takes one item per cycle unless a held-up result stalls it and
// keeps it in an input register; from there it does the whole control step
// (error, saturated error sum, three Q8.8 products, sum, shift by 8, last
// drive added in incremental mode, clamp) and loads the result register once
// that is free. The rate is set by the feedback loop from the controller
// history (error sum, last errors, last drive) through the multipliers and
// clamp back into the history registers. A clear item resets that history
// and gives no result. Configuration writes are always ready and must be
// made while no item is in flight.
module pid_controller_two_mode
    import pidc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  t_cfg_idx    i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_cfg      w_cfg;
    t_out_item w_result;
    t_state    w_state_next;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_state    r_state;

    logic      w_is_clear;
    logic      w_advance;
    logic      w_in_take;

    assign o_cfg_ready = 1'b1;

    pidc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid & o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    pidc_math u_math (
        .i_cfg    (w_cfg),
        .i_state  (r_state),
        .i_item   (r_in_item),
        .o_result (w_result),
        .o_state  (w_state_next)
    );

    assign w_is_clear = (r_in_item.req_type == REQ_CLEAR);
    // a clear item needs no output slot
    assign w_advance  = r_in_valid & (w_is_clear | ~r_out_valid | ~i_out_stall);
    assign o_in_stall = r_in_valid & ~w_advance;
    assign w_in_take  = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance & ~w_is_clear) begin
            r_out_valid <= 1'b1;
        end else if (~i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance & ~w_is_clear) begin
            r_out_item <= w_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_advance) begin
            r_state <= w_is_clear ? '0 : w_state_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== rtl/pidc_cfg.sv =====
`timescale 1ns / 1ps

module pidc_cfg
    import pidc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_we,
    input  t_cfg_idx    i_index,
    input  logic [31:0] i_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            unique case (i_index)
                CFG_MODE:    n_cfg.mode            = i_data[0];
                CFG_KP:      n_cfg.kp              = i_data[15:0];
                CFG_KI:      n_cfg.ki              = i_data[15:0];
                CFG_KD:      n_cfg.kd              = i_data[15:0];
                CFG_KI_TP:   n_cfg.ki_times_period = i_data[15:0];
                CFG_KD_OP:   n_cfg.kd_over_period  = i_data[15:0];
                CFG_OUT_MIN: n_cfg.out_min         = i_data;
                CFG_OUT_MAX: n_cfg.out_max         = i_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode            <= MODE_POSITIONAL;
            r_cfg.kp              <= '0;
            r_cfg.ki              <= '0;
            r_cfg.kd              <= '0;
            r_cfg.ki_times_period <= '0;
            r_cfg.kd_over_period  <= '0;
            r_cfg.out_min         <= 32'sh8000_0000;
            r_cfg.out_max         <= 32'sh7fff_ffff;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/pidc_math.sv =====
`timescale 1ns / 1ps

module pidc_math
    import pidc_pkg::*;
(
    input  t_cfg      i_cfg,
    input  t_state    i_state,
    input  t_in_item  i_item,
    output t_out_item o_result,
    output t_state    o_state
);

    logic signed [16:0] w_err;
    logic signed [32:0] w_sum_wide;
    logic signed [31:0] w_sum;
    logic signed [17:0] w_diff;

    logic signed [32:0] w_p_kp;
    logic signed [47:0] w_p_ki;
    logic signed [33:0] w_p_kd;

    logic signed [17:0] w_a0;
    logic signed [17:0] w_a1;
    logic signed [34:0] w_p_a0;
    logic signed [34:0] w_p_a1;
    logic signed [32:0] w_p_a2;

    logic signed [50:0] w_acc_pos;
    logic signed [36:0] w_acc_inc;
    logic signed [50:0] w_acc;
    logic signed [42:0] w_shifted;
    logic signed [43:0] w_raw;
    logic signed [43:0] w_max;
    logic signed [43:0] w_min;

    assign w_err = 17'(i_item.setpoint) - 17'(i_item.feedback);

    // saturate the running sum at 32 bits
    assign w_sum_wide = 33'(i_state.error_sum) + 33'(w_err);
    always_comb begin
        if (w_sum_wide[32] != w_sum_wide[31]) begin
            w_sum = w_sum_wide[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            w_sum = w_sum_wide[31:0];
        end
    end

    assign w_diff = 18'(w_err) - 18'(i_state.last_error);

    assign w_p_kp = i_cfg.kp * w_err;
    assign w_p_ki = i_cfg.ki * w_sum;
    assign w_p_kd = i_cfg.kd * w_diff;

    assign w_a0 = 18'(i_cfg.kp) + 18'(i_cfg.ki_times_period) + 18'(i_cfg.kd_over_period);
    assign w_a1 = 18'(i_cfg.kp) + (18'(i_cfg.kd_over_period) <<< 1);

    assign w_p_a0 = w_a0 * w_err;
    assign w_p_a1 = w_a1 * i_state.last_error;
    assign w_p_a2 = i_cfg.kd_over_period * i_state.previous_error;

    assign w_acc_pos = 51'(w_p_kp) + 51'(w_p_ki) + 51'(w_p_kd);
    assign w_acc_inc = 37'(w_p_a0) - 37'(w_p_a1) + 37'(w_p_a2);

    assign w_acc     = (i_cfg.mode == MODE_INCREMENTAL) ? 51'(w_acc_inc) : w_acc_pos;
    assign w_shifted = w_acc[50:8];

    always_comb begin
        if (i_cfg.mode == MODE_INCREMENTAL) begin
            w_raw = 44'(w_shifted) + 44'(i_state.last_drive);
        end else begin
            w_raw = 44'(w_shifted);
        end
    end

    assign w_max = 44'(i_cfg.out_max);
    assign w_min = 44'(i_cfg.out_min);

    // max test first, then min; min wins when the limits are inverted
    always_comb begin
        o_result.drive   = w_raw[31:0];
        o_result.limited = LIM_NONE;
        if (w_raw > w_max) begin
            o_result.drive   = i_cfg.out_max;
            o_result.limited = LIM_MAX;
            if (i_cfg.out_max < i_cfg.out_min) begin
                o_result.drive   = i_cfg.out_min;
                o_result.limited = LIM_MIN;
            end
        end else if (w_raw < w_min) begin
            o_result.drive   = i_cfg.out_min;
            o_result.limited = LIM_MIN;
        end
    end

    always_comb begin
        o_state.last_error     = w_err;
        o_state.previous_error = i_state.last_error;
        o_state.error_sum      = (i_cfg.mode == MODE_POSITIONAL) ? w_sum : i_state.error_sum;
        o_state.last_drive     = o_result.drive;
    end

endmodule

// ===== rtl/pidc_checker.sv =====
`timescale 1ns / 1ps

module pidc_checker
    import pidc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input t_out_item   o_out_item
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result item changed");

    a_limited_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.limited == LIM_NONE ||
                         o_out_item.limited == LIM_MAX ||
                         o_out_item.limited == LIM_MIN))
        else $error("limited flag carries an undefined code");

    // input back-pressure comes only from a blocked result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output back-pressure");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind pid_controller_two_mode pidc_checker u_pidc_checker (.*);

// ===== bench/tb_pid_controller_two_mode.sv =====
`timescale 1ns / 1ps

module tb_pid_controller_two_mode;
    import pidc_pkg::*;

    localparam int     CYCLE_LIMIT  = 500000;
    localparam int     RANDOM_ITEMS = 1100;
    localparam int     SWEEP_ITEMS  = 64;
    localparam longint SUM_MAX      = 64'sd2147483647;
    localparam longint SUM_MIN      = -64'sd2147483648;

    typedef struct packed {
        logic        is_cfg;
        t_cfg_idx    idx;
        logic [31:0] data;
        t_in_item    item;
        logic        typed;
        t_out_item   want;
    } t_dir_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_item   = '0;
    logic      i_out_stall = 1'b0;
    logic      i_cfg_valid = 1'b0;
    t_cfg_idx  i_cfg_index = CFG_MODE;
    logic [31:0] i_cfg_data = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;
    logic      o_cfg_ready;

    // sideband that travels with the item on the input channel
    logic      row_typed = 1'b0;
    t_out_item row_want  = '0;

    bit        idle_in_on   = 1'b0;
    bit        stall_out_on = 1'b0;
    int        err_count    = 0;
    int        cycle_count  = 0;

    t_out_item drive_expected[$];
    t_dir_row  dir_rows[$];

    // controller settings and history as the bench tracks them
    logic               ctl_mode;
    logic signed [15:0] ctl_kp, ctl_ki, ctl_kd, ctl_ki_tp, ctl_kd_op;
    logic signed [31:0] ctl_out_min, ctl_out_max;
    logic signed [16:0] hist_last_err, hist_prev_err;
    logic signed [31:0] hist_err_sum, hist_last_drive;

    pid_controller_two_mode dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit pid_predict(input t_in_item it, output t_out_item res);
        longint     err, sum, acc, raw, a0, a1, a2;
        logic [1:0] lim;
        res = '0;
        if (it.req_type == REQ_CLEAR) begin
            hist_last_err   = '0;
            hist_prev_err   = '0;
            hist_err_sum    = '0;
            hist_last_drive = '0;
            return 1'b0;
        end
        err = longint'(it.setpoint) - longint'(it.feedback);
        if (ctl_mode == MODE_POSITIONAL) begin
            sum = longint'(hist_err_sum) + err;
            if (sum > SUM_MAX) sum = SUM_MAX;
            if (sum < SUM_MIN) sum = SUM_MIN;
            hist_err_sum = sum[31:0];
            acc = longint'(ctl_kp) * err + longint'(ctl_ki) * sum
                + longint'(ctl_kd) * (err - longint'(hist_last_err));
            raw = acc >>> 8;
        end else begin
            a0  = longint'(ctl_kp) + longint'(ctl_ki_tp) + longint'(ctl_kd_op);
            a1  = longint'(ctl_kp) + 2 * longint'(ctl_kd_op);
            a2  = longint'(ctl_kd_op);
            acc = a0 * err - a1 * longint'(hist_last_err)
                + a2 * longint'(hist_prev_err);
            raw = longint'(hist_last_drive) + (acc >>> 8);
        end
        lim = LIM_NONE;
        // max first, then min: with inverted limits the min clamp wins
        if (raw > longint'(ctl_out_max)) begin
            raw = longint'(ctl_out_max);
            lim = LIM_MAX;
        end
        if (raw < longint'(ctl_out_min)) begin
            raw = longint'(ctl_out_min);
            lim = LIM_MIN;
        end
        hist_last_drive = raw[31:0];
        hist_prev_err   = hist_last_err;
        hist_last_err   = err[16:0];
        res.drive       = raw[31:0];
        res.limited     = lim;
        return 1'b1;
    endfunction

    function automatic t_dir_row row_cfg(t_cfg_idx idx, logic [31:0] data);
        t_dir_row r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        return r;
    endfunction

    function automatic t_dir_row row_run(logic req, logic [15:0] sp, logic [15:0] fb);
        t_dir_row r;
        r               = '0;
        r.idx           = CFG_MODE;
        r.item.req_type = req;
        r.item.setpoint = sp;
        r.item.feedback = fb;
        return r;
    endfunction

    function automatic t_dir_row row_chk(logic req, logic [15:0] sp, logic [15:0] fb,
                                         logic [31:0] drv, logic [1:0] lim);
        t_dir_row r;
        r              = row_run(req, sp, fb);
        r.typed        = 1'b1;
        r.want.drive   = drv;
        r.want.limited = lim;
        return r;
    endfunction

    function automatic logic [15:0] rand_gain();
        case ($urandom_range(0, 7))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3, 4: return 16'(int'($urandom_range(0, 1536)) - 768);
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3, 4: return 16'(int'($urandom_range(0, 400)) - 200);
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic send_item(t_in_item it, logic typed, t_out_item want);
        @(negedge i_clk);
        if (idle_in_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        row_typed  <= typed;
        row_want   <= want;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // drop valid, let every result arrive, then cover a clear still in flight
    task automatic quiesce();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (drive_expected.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_random_settings();
        logic [31:0]        val;
        logic signed [31:0] lo, hi, a, b;
        val = $urandom();
        write_reg(CFG_MODE, val);
        val = $urandom(); val[15:0] = rand_gain(); write_reg(CFG_KP, val);
        val = $urandom(); val[15:0] = rand_gain(); write_reg(CFG_KI, val);
        val = $urandom(); val[15:0] = rand_gain(); write_reg(CFG_KD, val);
        val = $urandom(); val[15:0] = rand_gain(); write_reg(CFG_KI_TP, val);
        val = $urandom(); val[15:0] = rand_gain(); write_reg(CFG_KD_OP, val);
        case ($urandom_range(0, 5))
            0, 1: begin
                lo = 32'h8000_0000;
                hi = 32'h7fff_ffff;
            end
            2: begin
                lo = -$signed($urandom_range(0, 5000));
                hi = $urandom_range(0, 5000);
            end
            3: begin
                a  = $urandom();
                b  = $urandom();
                lo = (a < b) ? a : b;
                hi = (a < b) ? b : a;
            end
            4: begin
                // inverted limits
                lo = $urandom_range(0, 3000);
                hi = -$signed($urandom_range(1, 3000));
            end
            default: begin
                lo = $urandom();
                hi = lo;
            end
        endcase
        write_reg(CFG_OUT_MIN, lo);
        write_reg(CFG_OUT_MAX, hi);
    endtask

    always begin
        @(negedge i_clk);
        if (stall_out_on && $urandom_range(0, 4) == 0) begin
            i_out_stall <= 1'b1;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_out_stall <= 1'b0;
    end

    always @(posedge i_clk) begin
        t_out_item pred, want;
        if (!i_rst_n) begin
            ctl_mode        = MODE_POSITIONAL;
            ctl_kp          = '0;
            ctl_ki          = '0;
            ctl_kd          = '0;
            ctl_ki_tp       = '0;
            ctl_kd_op       = '0;
            ctl_out_min     = 32'h8000_0000;
            ctl_out_max     = 32'h7fff_ffff;
            hist_last_err   = '0;
            hist_prev_err   = '0;
            hist_err_sum    = '0;
            hist_last_drive = '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MODE:    ctl_mode    = i_cfg_data[0];
                    CFG_KP:      ctl_kp      = i_cfg_data[15:0];
                    CFG_KI:      ctl_ki      = i_cfg_data[15:0];
                    CFG_KD:      ctl_kd      = i_cfg_data[15:0];
                    CFG_KI_TP:   ctl_ki_tp   = i_cfg_data[15:0];
                    CFG_KD_OP:   ctl_kd_op   = i_cfg_data[15:0];
                    CFG_OUT_MIN: ctl_out_min = i_cfg_data;
                    CFG_OUT_MAX: ctl_out_max = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                if (pid_predict(i_in_item, pred))
                    drive_expected.push_back(row_typed ? row_want : pred);
            end
            if (o_out_valid && !i_out_stall) begin
                if (drive_expected.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected result, expected none, actual drive %0d limited %0d",
                             $time, o_out_item.drive, o_out_item.limited);
                end else begin
                    want = drive_expected.pop_front();
                    if (o_out_item.drive !== want.drive) begin
                        err_count++;
                        $display("%0t: drive mismatch, expected %0d actual %0d",
                                 $time, want.drive, o_out_item.drive);
                    end
                    if (o_out_item.limited !== want.limited) begin
                        err_count++;
                        $display("%0t: limited mismatch, expected %0d actual %0d",
                                 $time, want.limited, o_out_item.limited);
                    end
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: timeout, %0d results still expected", $time, drive_expected.size());
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        t_in_item it;
        int       rand_items;
        int       n;
        bit       first_phase;

        // gains at reset are zero, so the first rows read off directly
        dir_rows.push_back(row_chk(REQ_COMPUTE, 16'h0000, 16'h0000, 32'd0, LIM_NONE));
        dir_rows.push_back(row_chk(REQ_COMPUTE, 16'h7fff, 16'h8000, 32'd0, LIM_NONE));
        dir_rows.push_back(row_chk(REQ_COMPUTE, 16'h8000, 16'h7fff, 32'd0, LIM_NONE));
        dir_rows.push_back(row_run(REQ_CLEAR, 16'h1234, 16'h5678));
        dir_rows.push_back(row_cfg(CFG_OUT_MAX, -32'sd5));
        dir_rows.push_back(row_chk(REQ_COMPUTE, 16'h0010, 16'h0020, -32'sd5, LIM_MAX));
        dir_rows.push_back(row_cfg(CFG_OUT_MIN, 32'd200));
        dir_rows.push_back(row_cfg(CFG_OUT_MAX, 32'd100));
        dir_rows.push_back(row_chk(REQ_COMPUTE, 16'h0001, 16'h0002, 32'd200, LIM_MIN));
        // above max and below min at once: min clamp wins
        dir_rows.push_back(row_cfg(CFG_OUT_MIN, 32'd10));
        dir_rows.push_back(row_cfg(CFG_OUT_MAX, -32'sd10));
        dir_rows.push_back(row_chk(REQ_COMPUTE, 16'h0005, 16'h0003, 32'd10, LIM_MIN));
        dir_rows.push_back(row_cfg(CFG_OUT_MIN, 32'h8000_0000));
        dir_rows.push_back(row_cfg(CFG_OUT_MAX, 32'h7fff_ffff));
        dir_rows.push_back(row_cfg(CFG_KP, 32'h0000_7fff));
        dir_rows.push_back(row_cfg(CFG_KI, 32'h0000_8000));
        dir_rows.push_back(row_cfg(CFG_KD, 32'h0000_7fff));
        dir_rows.push_back(row_run(REQ_COMPUTE, 16'h7fff, 16'h8000));
        dir_rows.push_back(row_run(REQ_COMPUTE, 16'h8000, 16'h7fff));
        dir_rows.push_back(row_run(REQ_COMPUTE, 16'h8000, 16'h7fff));
        dir_rows.push_back(row_run(REQ_COMPUTE, 16'h0000, 16'h0000));
        dir_rows.push_back(row_run(REQ_CLEAR, 16'hffff, 16'hffff));
        dir_rows.push_back(row_run(REQ_COMPUTE, 16'h0001, 16'h0000));
        // unit and half gain: shift rounds toward minus infinity
        dir_rows.push_back(row_cfg(CFG_KI, 32'h0000_0000));
        dir_rows.push_back(row_cfg(CFG_KD, 32'h0000_0000));
        dir_rows.push_back(row_cfg(CFG_KP, 32'h0000_0100));
        dir_rows.push_back(row_chk(REQ_COMPUTE, 16'd100, 16'd0, 32'd100, LIM_NONE));
        dir_rows.push_back(row_cfg(CFG_KP, 32'h0000_0080));
        dir_rows.push_back(row_chk(REQ_COMPUTE, -16'sd3, 16'd0, -32'sd2, LIM_NONE));
        dir_rows.push_back(row_chk(REQ_COMPUTE, 16'd3, 16'd0, 32'd1, LIM_NONE));
        dir_rows.push_back(row_cfg(CFG_MODE, 32'(MODE_INCREMENTAL)));
        dir_rows.push_back(row_cfg(CFG_KP, 32'h0000_0100));
        dir_rows.push_back(row_cfg(CFG_KI_TP, 32'h0000_0080));
        dir_rows.push_back(row_cfg(CFG_KD_OP, 32'h0000_0040));
        dir_rows.push_back(row_run(REQ_CLEAR, 16'h0000, 16'h0000));
        dir_rows.push_back(row_run(REQ_COMPUTE, 16'd1000, 16'd0));
        dir_rows.push_back(row_run(REQ_COMPUTE, 16'd1000, 16'd500));
        dir_rows.push_back(row_run(REQ_COMPUTE, 16'h8000, 16'h7fff));
        dir_rows.push_back(row_run(REQ_COMPUTE, 16'h7fff, 16'h8000));
        dir_rows.push_back(row_run(REQ_COMPUTE, 16'h0000, 16'h0000));
        dir_rows.push_back(row_cfg(CFG_KI_TP, 32'h0000_8000));
        dir_rows.push_back(row_cfg(CFG_KD_OP, 32'h0000_7fff));
        dir_rows.push_back(row_run(REQ_COMPUTE, 16'h7fff, 16'h8000));
        dir_rows.push_back(row_run(REQ_COMPUTE, 16'h8000, 16'h7fff));
        dir_rows.push_back(row_run(REQ_COMPUTE, 16'h0000, 16'h0000));

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        idle_in_on   = 1'b1;
        stall_out_on = 1'b1;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                quiesce();
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            end else begin
                send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        // push full-scale errors of both signs through, back to back
        idle_in_on   = 1'b0;
        stall_out_on = 1'b0;
        quiesce();
        write_reg(CFG_MODE, 32'(MODE_POSITIONAL));
        write_reg(CFG_KP, 32'(rand_gain()));
        write_reg(CFG_KI, 32'(rand_gain()));
        write_reg(CFG_KD, 32'(rand_gain()));
        write_reg(CFG_OUT_MIN, 32'h8000_0000);
        write_reg(CFG_OUT_MAX, 32'h7fff_ffff);
        it = '0;
        it.req_type = REQ_CLEAR;
        send_item(it, 1'b0, '0);
        it.req_type = REQ_COMPUTE;
        for (int k = 0; k < SWEEP_ITEMS; k++) begin
            it.setpoint = 16'h7fff - 16'($urandom_range(0, 3));
            it.feedback = 16'h8000;
            send_item(it, 1'b0, '0);
        end
        for (int k = 0; k < 8; k++) begin
            it.setpoint = rand_sample();
            it.feedback = rand_sample();
            send_item(it, 1'b0, '0);
        end
        it.req_type = REQ_CLEAR;
        send_item(it, 1'b0, '0);
        it.req_type = REQ_COMPUTE;
        for (int k = 0; k < SWEEP_ITEMS; k++) begin
            it.setpoint = 16'h8000;
            it.feedback = 16'h7fff - 16'($urandom_range(0, 3));
            send_item(it, 1'b0, '0);
        end
        for (int k = 0; k < 8; k++) begin
            it.setpoint = rand_sample();
            it.feedback = rand_sample();
            send_item(it, 1'b0, '0);
        end

        rand_items  = 0;
        first_phase = 1'b1;
        while (rand_items < RANDOM_ITEMS) begin
            if (rand_items >= RANDOM_ITEMS - 200) begin
                idle_in_on   = 1'b0;
                stall_out_on = 1'b0;
            end else begin
                idle_in_on   = ($urandom_range(0, 3) != 0);
                stall_out_on = ($urandom_range(0, 3) != 0);
            end
            quiesce();
            write_random_settings();
            n = $urandom_range(40, 160);
            for (int k = 0; k < n; k++) begin
                // hold the sender until the pipe is empty
                if (k == n / 2 && (first_phase || $urandom_range(0, 2) == 0))
                    quiesce();
                it.req_type = ($urandom_range(0, 24) == 0) ? REQ_CLEAR : REQ_COMPUTE;
                it.setpoint = rand_sample();
                it.feedback = rand_sample();
                send_item(it, 1'b0, '0);
                rand_items++;
            end
            first_phase = 1'b0;
        end

        idle_in_on   = 1'b0;
        stall_out_on = 1'b0;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (drive_expected.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== pid_controller_two_mode.f =====
rtl/pidc_pkg.sv
rtl/pidc_cfg.sv
rtl/pidc_math.sv
rtl/pid_controller_two_mode.sv
rtl/pidc_checker.sv
bench/tb_pid_controller_two_mode.sv
